>>> hw/rtl/particle_pool_integrator_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the particle pool integrator
// Shared helpers that wrap concurrent assertions clocked on the core clock.
// ----------------------------------------------------------------------------
`ifndef PARTICLE_POOL_INTEGRATOR_CORE_DEFINES_SVH
`define PARTICLE_POOL_INTEGRATOR_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define PPI_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define PPI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/ppi_pkg.sv
// ----------------------------------------------------------------------------
// Particle pool integrator package
// Sizes, codes and the controller to datapath command and status words.
// ----------------------------------------------------------------------------
`default_nettype none

package ppi_pkg;

    localparam int unsigned PPI_MAX = 64;
    localparam int unsigned PPI_AW  = (PPI_MAX > 1) ? $clog2(PPI_MAX) : 1;
    localparam int unsigned PPI_CW  = $clog2(PPI_MAX + 1);

    // Operation codes of an input word.
    typedef enum logic [1:0] {
        OP_EMIT  = 2'd0,
        OP_TICK  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_SCALE_START = 3'd0,
        CFG_SCALE_END   = 3'd1,
        CFG_COLOR_START = 3'd2,
        CFG_COLOR_END   = 3'd3,
        CFG_GRAVITY     = 3'd4,
        CFG_DRAG        = 3'd5,
        CFG_OFFSET      = 3'd6,
        CFG_POOL_CTRL   = 3'd7
    } t_cfg_idx;

    // One stored particle.
    typedef struct packed {
        logic [31:0] life;
        logic [31:0] age;
        logic [31:0] vel_z;
        logic [31:0] vel_y;
        logic [31:0] vel_x;
        logic [31:0] pos_z;
        logic [31:0] pos_y;
        logic [31:0] pos_x;
    } t_rec;

    // Commands from the controller.
    typedef struct packed {
        logic       start;
        logic       emit;
        logic       clear;
        logic       age;
        logic       div;
        logic       axis;
        logic       lerp;
        logic       wr;
        logic       flush;
        logic [2:0] idx;
        logic [3:0] ph;
    } t_cmd;

    // Status back to the controller.
    typedef struct packed {
        logic more;
        logic alive;
        logic hold_valid;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

>>> hw/rtl/ppi_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ppi_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 64
) (
    input  wire logic                                     i_clk,
    input  wire logic                                     i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                         i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

>>> hw/rtl/ppi_datapath.sv
// ----------------------------------------------------------------------------
// Particle pool integrator datapath
// Configuration registers, particle store, divider, shared multiplier,
// result staging and output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "particle_pool_integrator_core_defines.svh"

module ppi_datapath (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_valid,
    input  wire logic [2:0]           i_cfg_index,
    input  wire logic [63:0]          i_cfg_data,
    input  wire logic [15:0]          i_time_step,
    input  wire logic signed [31:0]   i_start_pos_x,
    input  wire logic signed [31:0]   i_start_pos_y,
    input  wire logic signed [31:0]   i_start_pos_z,
    input  wire logic signed [31:0]   i_start_vel_x,
    input  wire logic signed [31:0]   i_start_vel_y,
    input  wire logic signed [31:0]   i_start_vel_z,
    input  wire logic [31:0]          i_life_span,
    input  wire ppi_pkg::t_cmd        i_cmd,
    output ppi_pkg::t_sts             o_sts,
    input  wire logic                 i_out_stall,
    output logic                      o_out_valid,
    output logic signed [31:0]        o_out_pos_x,
    output logic signed [31:0]        o_out_pos_y,
    output logic signed [31:0]        o_out_pos_z,
    output logic signed [15:0]        o_out_scale_x,
    output logic signed [15:0]        o_out_scale_y,
    output logic signed [15:0]        o_out_scale_z,
    output logic [15:0]               o_out_red,
    output logic [15:0]               o_out_green,
    output logic [15:0]               o_out_blue,
    output logic [15:0]               o_out_alpha,
    output logic                      o_last_of_tick,
    output logic                      o_pool_empty
);

    import ppi_pkg::*;

    localparam logic signed [33:0] L_SAT_MAX = 34'sd2147483647;
    localparam logic signed [33:0] L_SAT_MIN = -34'sd2147483648;

    // Configuration registers.
    logic [47:0] r_scale_start, r_scale_end, r_gravity, r_offset;
    logic [63:0] r_color_start, r_color_end;
    logic [15:0] r_drag;
    logic [7:0]  r_pool_ctrl;

    // Pool and scan state.
    logic [PPI_CW-1:0] r_count, r_n, r_rd, r_wr;
    logic [15:0]       r_dt;
    logic [24:0]       r_dragf;

    // Working particle.
    logic [31:0]        r_pos [3];
    logic [31:0]        r_vel [3];
    logic [31:0]        r_age, r_life, r_rem;
    logic [15:0]        r_q;
    logic [31:0]        r_vt;
    logic signed [57:0] r_prod;
    logic [15:0]        r_lerp [7];

    // Staged and output results.
    logic        r_hold_valid;
    logic [31:0] r_hold_pos [3];
    logic [15:0] r_hold_lerp [7];
    logic        r_out_valid, r_out_last, r_out_empty;
    logic [31:0] r_out_pos [3];
    logic [15:0] r_out_lerp [7];

    logic        w_out_free;
    logic        w_emit_ok;
    logic [7:0]  w_lim;
    logic        w_we;
    logic [PPI_AW-1:0] w_waddr;
    t_rec        w_wrec, w_rrec;
    logic [32:0] w_age_sum;
    logic [31:0] w_age_sat;
    logic [32:0] w_trial;
    logic [31:0] w_dragp;
    logic [1:0]  w_axis;
    logic [1:0]  w_chan;
    logic signed [31:0] w_ma;
    logic signed [25:0] w_mb;
    logic signed [57:0] w_mp;
    logic signed [57:0] w_sh8, w_sh16, w_sh24;
    logic signed [33:0] w_vs;
    logic [31:0] w_vsat;
    logic [31:0] w_offs;
    logic signed [16:0] w_la, w_lb, w_ldiff;
    logic [15:0] w_lres;

    function automatic logic [15:0] half(input logic [63:0] v, input logic [1:0] k);
        half = v[{k, 4'b0000} +: 16];
    endfunction

    // Configuration writes; the port is always ready.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale_start <= '0;
            r_scale_end   <= '0;
            r_color_start <= '0;
            r_color_end   <= '0;
            r_gravity     <= '0;
            r_drag        <= '0;
            r_offset      <= '0;
            r_pool_ctrl   <= 8'd129;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_SCALE_START: r_scale_start <= i_cfg_data[47:0];
                CFG_SCALE_END:   r_scale_end   <= i_cfg_data[47:0];
                CFG_COLOR_START: r_color_start <= i_cfg_data;
                CFG_COLOR_END:   r_color_end   <= i_cfg_data;
                CFG_GRAVITY:     r_gravity     <= i_cfg_data[47:0];
                CFG_DRAG:        r_drag        <= i_cfg_data[15:0];
                CFG_OFFSET:      r_offset      <= i_cfg_data[47:0];
                CFG_POOL_CTRL:   r_pool_ctrl   <= i_cfg_data[7:0];
                default:         r_pool_ctrl   <= r_pool_ctrl;
            endcase
        end
    end

    // Emission limit, clamped to the store depth.
    assign w_lim     = (r_pool_ctrl[7:1] > 7'(PPI_MAX)) ? 8'(PPI_MAX) : {1'b0, r_pool_ctrl[7:1]};
    assign w_emit_ok = 8'(r_count) < w_lim;

    // Store write port: emission appends, a survivor is written back compacted.
    always_comb begin
        w_wrec.pos_x = i_start_pos_x;
        w_wrec.pos_y = i_start_pos_y;
        w_wrec.pos_z = i_start_pos_z;
        w_wrec.vel_x = i_start_vel_x;
        w_wrec.vel_y = i_start_vel_y;
        w_wrec.vel_z = i_start_vel_z;
        w_wrec.age   = '0;
        w_wrec.life  = i_life_span;
        w_waddr      = r_count[PPI_AW-1:0];
        if (i_cmd.wr) begin
            w_wrec.pos_x = r_pos[0];
            w_wrec.pos_y = r_pos[1];
            w_wrec.pos_z = r_pos[2];
            w_wrec.vel_x = r_vel[0];
            w_wrec.vel_y = r_vel[1];
            w_wrec.vel_z = r_vel[2];
            w_wrec.age   = r_age;
            w_wrec.life  = r_life;
            w_waddr      = r_wr[PPI_AW-1:0];
        end
    end
    assign w_we = (i_cmd.emit && w_emit_ok) || i_cmd.wr;

    ppi_ram #(
        .WIDTH ($bits(t_rec)),
        .DEPTH (PPI_MAX)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wrec),
        .i_raddr (r_rd[PPI_AW-1:0]),
        .o_rdata (w_rrec)
    );

    // Aging with saturation and the expiry test.
    assign w_age_sum = {1'b0, w_rrec.age} + {17'b0, r_dt};
    assign w_age_sat = w_age_sum[32] ? 32'hFFFF_FFFF : w_age_sum[31:0];

    // One quotient bit per divider step.
    assign w_trial = {r_rem, 1'b0};

    // Drag factor for the tick.
    assign w_dragp = r_drag * i_time_step;

    // Shared multiplier operand selection.
    assign w_axis = i_cmd.idx[1:0];
    assign w_chan = 2'(i_cmd.idx - 3'd3);
    always_comb begin
        if (i_cmd.idx < 3'd3) begin
            w_la = 17'(signed'(half({16'b0, r_scale_start}, w_axis)));
            w_lb = 17'(signed'(half({16'b0, r_scale_end}, w_axis)));
        end else begin
            w_la = {1'b0, half(r_color_start, w_chan)};
            w_lb = {1'b0, half(r_color_end, w_chan)};
        end
    end
    assign w_ldiff = w_lb - w_la;

    always_comb begin
        w_ma = '0;
        w_mb = '0;
        if (i_cmd.axis) begin
            case (i_cmd.ph)
                4'd0: begin
                    w_ma = 32'(signed'(half({16'b0, r_gravity}, w_axis)));
                    w_mb = {10'b0, r_dt};
                end
                4'd2: begin
                    w_ma = r_vt;
                    w_mb = {1'b0, r_dragf};
                end
                4'd4: begin
                    w_ma = r_vt;
                    w_mb = {10'b0, r_dt};
                end
                default: begin
                    w_ma = '0;
                    w_mb = '0;
                end
            endcase
        end else if (i_cmd.lerp) begin
            w_ma = 32'(w_ldiff);
            w_mb = {10'b0, r_q};
        end
    end
    assign w_mp = w_ma * w_mb;

    // Rounded shifts of the registered product, ties toward plus infinity.
    assign w_sh8  = (r_prod + 58'sd128) >>> 8;
    assign w_sh16 = (r_prod + 58'sd32768) >>> 16;
    assign w_sh24 = (r_prod + 58'sd8388608) >>> 24;

    assign w_vs   = 34'(signed'(r_vel[w_axis])) + w_sh8[33:0];
    assign w_vsat = (w_vs > L_SAT_MAX) ? 32'h7FFF_FFFF :
                    (w_vs < L_SAT_MIN) ? 32'h8000_0000 : w_vs[31:0];
    assign w_offs = r_pool_ctrl[0] ? 32'd0 :
                    {24'(signed'(half({16'b0, r_offset}, w_axis))), 8'b0};
    assign w_lres = 16'(w_la + w_sh16[16:0]);

    // Scan control and arithmetic sequence.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_n     <= '0;
            r_rd    <= '0;
            r_wr    <= '0;
        end else begin
            if (i_cmd.clear) begin
                r_count <= '0;
            end else if (i_cmd.emit && w_emit_ok) begin
                r_count <= r_count + 1'b1;
            end else if (i_cmd.flush) begin
                r_count <= r_wr;
            end
            if (i_cmd.start) begin
                r_n  <= r_count;
                r_rd <= '0;
                r_wr <= '0;
            end
            if (i_cmd.age) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_cmd.wr) begin
                r_wr <= r_wr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_dt    <= i_time_step;
            r_dragf <= (w_dragp >= 32'h0100_0000) ? 25'd0 : 25'(32'h0100_0000 - w_dragp);
        end
        if (i_cmd.age) begin
            r_pos[0] <= w_rrec.pos_x;
            r_pos[1] <= w_rrec.pos_y;
            r_pos[2] <= w_rrec.pos_z;
            r_vel[0] <= w_rrec.vel_x;
            r_vel[1] <= w_rrec.vel_y;
            r_vel[2] <= w_rrec.vel_z;
            r_age    <= w_age_sat;
            r_life   <= w_rrec.life;
            r_rem    <= w_age_sat;
            r_q      <= '0;
        end
        if (i_cmd.div) begin
            if (w_trial >= {1'b0, r_life}) begin
                r_rem <= 32'(w_trial - {1'b0, r_life});
                r_q   <= {r_q[14:0], 1'b1};
            end else begin
                r_rem <= w_trial[31:0];
                r_q   <= {r_q[14:0], 1'b0};
            end
        end
        if (i_cmd.axis) begin
            case (i_cmd.ph)
                4'd1:    r_vt <= w_vsat;
                4'd3:    r_vt <= w_sh24[31:0];
                4'd5: begin
                    r_pos[w_axis] <= r_pos[w_axis] + w_sh16[31:0] + w_offs;
                    r_vel[w_axis] <= r_vt;
                end
                default: r_prod <= w_mp;
            endcase
        end
        if (i_cmd.lerp) begin
            if (i_cmd.ph == 4'd0) begin
                r_prod <= w_mp;
            end else begin
                r_lerp[i_cmd.idx] <= w_lres;
            end
        end
    end

    // Result staging: a result waits until the scan shows whether it is the last.
    assign w_out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.start || i_cmd.flush) begin
                r_hold_valid <= 1'b0;
            end else if (i_cmd.wr) begin
                r_hold_valid <= 1'b1;
            end
            if ((i_cmd.wr && r_hold_valid) || i_cmd.flush) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr) begin
            r_hold_pos  <= r_pos;
            r_hold_lerp <= r_lerp;
        end
        if ((i_cmd.wr && r_hold_valid) || (i_cmd.flush && r_hold_valid)) begin
            r_out_pos   <= r_hold_pos;
            r_out_lerp  <= r_hold_lerp;
            r_out_last  <= i_cmd.flush;
            r_out_empty <= 1'b0;
        end else if (i_cmd.flush) begin
            r_out_pos   <= '{default: '0};
            r_out_lerp  <= '{default: '0};
            r_out_last  <= 1'b1;
            r_out_empty <= 1'b1;
        end
    end

    // Status.
    assign o_sts.more       = r_rd < r_n;
    assign o_sts.alive      = w_age_sat < w_rrec.life;
    assign o_sts.hold_valid = r_hold_valid;
    assign o_sts.out_free   = w_out_free;

    // Output word.
    assign o_out_valid    = r_out_valid;
    assign o_out_pos_x    = r_out_pos[0];
    assign o_out_pos_y    = r_out_pos[1];
    assign o_out_pos_z    = r_out_pos[2];
    assign o_out_scale_x  = r_out_lerp[0];
    assign o_out_scale_y  = r_out_lerp[1];
    assign o_out_scale_z  = r_out_lerp[2];
    assign o_out_red      = r_out_lerp[3];
    assign o_out_green    = r_out_lerp[4];
    assign o_out_blue     = r_out_lerp[5];
    assign o_out_alpha    = r_out_lerp[6];
    assign o_last_of_tick = r_out_last;
    assign o_pool_empty   = r_out_empty;

    // Compaction never overtakes the scan, and no result is overwritten.
    `PPI_ASSERT_NOW(a_wr_behind_rd, 1'b1, r_wr <= r_rd, "write index passed read index")
    `PPI_ASSERT_NOW(a_push_free, i_cmd.wr && r_hold_valid, w_out_free, "result overwritten")
    `PPI_ASSERT_NEXT(a_flush_last, i_cmd.flush, r_out_valid && r_out_last, "tick end lost")

endmodule

`default_nettype wire

>>> hw/rtl/ppi_ctrl.sv
// ----------------------------------------------------------------------------
// Particle pool integrator controller
// Sequences emission, clearing and the per-particle tick steps.
// ----------------------------------------------------------------------------
`default_nettype none

module ppi_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire logic [1:0]    i_operation,
    input  wire logic [15:0]   i_time_step,
    input  wire ppi_pkg::t_sts i_sts,
    output ppi_pkg::t_cmd      o_cmd
);

    import ppi_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_NEXT  = 8'b0000_0010,
        S_AGE   = 8'b0000_0100,
        S_DIV   = 8'b0000_1000,
        S_AXIS  = 8'b0001_0000,
        S_LERP  = 8'b0010_0000,
        S_WR    = 8'b0100_0000,
        S_FLUSH = 8'b1000_0000
    } t_state;

    t_state     r_state, n_state;
    logic [3:0] r_cnt, n_cnt;
    logic [2:0] r_idx, n_idx;

    assign o_in_stall = (r_state != S_IDLE);

    // Next state and commands.
    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_idx     = r_idx;
        o_cmd     = '0;
        o_cmd.idx = r_idx;
        o_cmd.ph  = r_cnt;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    case (t_op'(i_operation))
                        OP_EMIT:  o_cmd.emit = 1'b1;
                        OP_CLEAR: o_cmd.clear = 1'b1;
                        OP_TICK: begin
                            if (i_time_step != 16'd0) begin
                                o_cmd.start = 1'b1;
                                n_state     = S_NEXT;
                            end
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_NEXT: begin
                n_state = i_sts.more ? S_AGE : S_FLUSH;
            end
            S_AGE: begin
                o_cmd.age = 1'b1;
                n_cnt     = '0;
                n_state   = i_sts.alive ? S_DIV : S_NEXT;
            end
            S_DIV: begin
                o_cmd.div = 1'b1;
                n_cnt     = r_cnt + 1'b1;
                if (r_cnt == 4'd15) begin
                    n_cnt   = '0;
                    n_idx   = '0;
                    n_state = S_AXIS;
                end
            end
            S_AXIS: begin
                o_cmd.axis = 1'b1;
                n_cnt      = r_cnt + 1'b1;
                if (r_cnt == 4'd5) begin
                    n_cnt = '0;
                    n_idx = r_idx + 1'b1;
                    if (r_idx == 3'd2) begin
                        n_idx   = '0;
                        n_state = S_LERP;
                    end
                end
            end
            S_LERP: begin
                o_cmd.lerp = 1'b1;
                n_cnt      = r_cnt + 1'b1;
                if (r_cnt == 4'd1) begin
                    n_cnt = '0;
                    n_idx = r_idx + 1'b1;
                    if (r_idx == 3'd6) begin
                        n_idx   = '0;
                        n_state = S_WR;
                    end
                end
            end
            S_WR: begin
                if (!i_sts.hold_valid || i_sts.out_free) begin
                    o_cmd.wr = 1'b1;
                    n_state  = S_NEXT;
                end
            end
            S_FLUSH: begin
                if (i_sts.out_free) begin
                    o_cmd.flush = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_idx   <= n_idx;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/particle_pool_integrator_core.sv
// ----------------------------------------------------------------------------
// Particle pool integrator core
// Ordered particle pool with fixed-point Euler update, aging and lerped looks.
//
//   Channel  Direction  Handshake             Word
//   input    in         i_in_valid/o_in_stall emit, tick or clear item
//   output   out        o_out_valid/i_out_stall one surviving particle
//   config   in         i_cfg_valid/o_cfg_ready register index and data
//
// Emit, clear, unused operations and zero-step ticks are accepted in the idle state.
// A tick ages every stored particle and drops the expired ones; each survivor
// passes the 16-step age/lifetime divider and the shared multiplier sequence.
// Synchronous active-low reset empties the pool; no clearing pass is needed.
// Output stalls hold the scan only when a staged result cannot move on.
// ----------------------------------------------------------------------------
`default_nettype none

module particle_pool_integrator_core (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire logic [1:0]           i_operation,
    input  wire logic [15:0]          i_time_step,
    input  wire logic signed [31:0]   i_start_pos_x,
    input  wire logic signed [31:0]   i_start_pos_y,
    input  wire logic signed [31:0]   i_start_pos_z,
    input  wire logic signed [31:0]   i_start_vel_x,
    input  wire logic signed [31:0]   i_start_vel_y,
    input  wire logic signed [31:0]   i_start_vel_z,
    input  wire logic [31:0]          i_life_span,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output logic signed [31:0]        o_out_pos_x,
    output logic signed [31:0]        o_out_pos_y,
    output logic signed [31:0]        o_out_pos_z,
    output logic signed [15:0]        o_out_scale_x,
    output logic signed [15:0]        o_out_scale_y,
    output logic signed [15:0]        o_out_scale_z,
    output logic [15:0]               o_out_red,
    output logic [15:0]               o_out_green,
    output logic [15:0]               o_out_blue,
    output logic [15:0]               o_out_alpha,
    output logic                      o_last_of_tick,
    output logic                      o_pool_empty,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [2:0]           i_cfg_index,
    input  wire logic [63:0]          i_cfg_data
);

    import ppi_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    // Registers are plain flops and always take a write.
    assign o_cfg_ready = 1'b1;

    ppi_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_operation (i_operation),
        .i_time_step (i_time_step),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    ppi_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_time_step    (i_time_step),
        .i_start_pos_x  (i_start_pos_x),
        .i_start_pos_y  (i_start_pos_y),
        .i_start_pos_z  (i_start_pos_z),
        .i_start_vel_x  (i_start_vel_x),
        .i_start_vel_y  (i_start_vel_y),
        .i_start_vel_z  (i_start_vel_z),
        .i_life_span    (i_life_span),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_out_pos_x    (o_out_pos_x),
        .o_out_pos_y    (o_out_pos_y),
        .o_out_pos_z    (o_out_pos_z),
        .o_out_scale_x  (o_out_scale_x),
        .o_out_scale_y  (o_out_scale_y),
        .o_out_scale_z  (o_out_scale_z),
        .o_out_red      (o_out_red),
        .o_out_green    (o_out_green),
        .o_out_blue     (o_out_blue),
        .o_out_alpha    (o_out_alpha),
        .o_last_of_tick (o_last_of_tick),
        .o_pool_empty   (o_pool_empty)
    );

endmodule

`default_nettype wire
